// ===== sv/rmst_pkg.sv =====
// shared types, codes and defaults for the range-query sparse table
package rmst_pkg;

	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int LEVELS_DEF       = 11;
	localparam int DATA_W           = 64;
	localparam int IDX_W            = 11;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [1:0]               opcode_t;
	typedef logic [1:0]               status_t;
	typedef logic [1:0]               mode_t;

	localparam opcode_t OP_CLEAR  = 2'd0;
	localparam opcode_t OP_APPEND = 2'd1;
	localparam opcode_t OP_QUERY  = 2'd2;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_BAD  = 2'd1;
	localparam status_t ST_FULL = 2'd2;

	localparam mode_t MODE_MIN = 2'd0;
	localparam mode_t MODE_MAX = 2'd1;
	localparam mode_t MODE_AND = 2'd2;
	localparam mode_t MODE_OR  = 2'd3;

endpackage

// ===== sv/range_min_sparse_table_core.sv =====
// Sparse-table range query over signed 64-bit values, built incrementally as values are
// appended. One transaction is taken at a time and gives one result. A clear, an unused
// opcode, a bad range or an append to a full table goes from accept straight to S_DONE;
// an append at one-based index n fills the m levels above 0 whose window ends at n
// (m = min(floor(log2(n)), LEVELS-1)) in S_LEVEL, since the single table read port and
// the shared merge unit handle one level per cycle; a query over a range of length len
// reads level k = min(floor(log2(len)), LEVELS-1), found by the one-level-per-cycle log
// search in S_QLOG, and then makes two reads through the same port.
// The table needs no clearing pass after reset. The result sits in an output register,
// so the next transaction may be accepted while it waits.
module range_min_sparse_table_core #(
	parameter int MAX_ELEMENTS = rmst_pkg::MAX_ELEMENTS_DEF,
	parameter int LEVELS       = rmst_pkg::LEVELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  rmst_pkg::mode_t     cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  rmst_pkg::opcode_t   opcode,
	input  rmst_pkg::data_t     value,
	input  rmst_pkg::idx_t      left_index,
	input  rmst_pkg::idx_t      right_index,
	output logic                out_valid,
	input  logic                out_stall,
	output rmst_pkg::data_t     answer,
	output rmst_pkg::status_t   status
);

	localparam int DEPTH = LEVELS * MAX_ELEMENTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int KW    = $clog2(LEVELS);
	localparam int DW0   = (CW > LEVELS) ? CW : LEVELS;
	localparam int DW    = (DW0 > rmst_pkg::IDX_W + 1) ? DW0 : rmst_pkg::IDX_W + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LEVEL = 3'd1;
	localparam logic [2:0] S_QLOG  = 3'd2;
	localparam logic [2:0] S_QRD2  = 3'd3;
	localparam logic [2:0] S_QMRG  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]        state_q;
	logic [CW-1:0]     count_q;
	rmst_pkg::mode_t   mode_q;
	logic [KW-1:0]     k_q;
	logic [AW-1:0]     base_q;
	logic [DW-1:0]     start_q;
	logic [DW-1:0]     pos1_q;
	rmst_pkg::data_t   acc_q;
	rmst_pkg::idx_t    len_q;
	rmst_pkg::idx_t    l_q;
	rmst_pkg::idx_t    r_q;
	rmst_pkg::data_t   res_ans_q;
	rmst_pkg::status_t res_stat_q;
	logic              out_valid_q;
	rmst_pkg::data_t   answer_q;
	rmst_pkg::status_t status_q;

	logic              in_take;
	logic              full;
	logic              bad_range;
	logic [DW-1:0]     pos_w;
	logic [DW-1:0]     pos1_w;
	logic [KW-1:0]     k_next;
	logic              k_last;
	logic [DW-1:0]     pow_next;
	logic [DW-1:0]     start_next;
	logic [DW-1:0]     span;
	logic              lvl_more;
	logic              q_more;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	rmst_pkg::data_t   mem_wdata;
	logic [AW-1:0]     mem_raddr;
	rmst_pkg::data_t   mem_rdata;

	rmst_pkg::data_t   mrg_x;
	rmst_pkg::data_t   mrg_y;
	rmst_pkg::data_t   mrg_out;

	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign full      = (count_q == CW'(MAX_ELEMENTS));
	assign pos_w     = DW'(count_q);
	assign pos1_w    = pos_w + DW'(1);
	assign bad_range = (left_index == '0) || (left_index > right_index)
		|| (DW'(right_index) > DW'(count_q));

	assign k_next     = k_q + KW'(1);
	assign k_last     = (k_q == KW'(LEVELS - 1));
	assign pow_next   = DW'(1) << k_next;
	assign start_next = pos1_q - pow_next;
	assign span       = DW'(1) << k_q;
	assign lvl_more   = !k_last && (pos1_q >= pow_next);
	assign q_more     = !k_last && ((len_q >> k_next) != '0);

	always_comb begin
		if (state_q == S_QMRG) begin
			mrg_x = acc_q;
			mrg_y = mem_rdata;
		end else begin
			mrg_x = mem_rdata;
			mrg_y = acc_q;
		end
	end

	rmst_merge u_merge (
		.mode   (mode_q),
		.x      (mrg_x),
		.y      (mrg_y),
		.result (mrg_out)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = value;
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_take && opcode == rmst_pkg::OP_APPEND && !full) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(pos_w);
					mem_wdata = value;
					mem_raddr = AW'(pos_w - DW'(1));
				end
			end
			S_LEVEL: begin
				mem_we    = 1'b1;
				mem_waddr = base_q + AW'(start_q);
				mem_wdata = mrg_out;
				mem_raddr = base_q + AW'(start_next);
			end
			S_QLOG: begin
				mem_raddr = base_q + AW'(DW'(l_q) - DW'(1));
			end
			S_QRD2: begin
				mem_raddr = base_q + AW'(DW'(r_q) - span);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	rmst_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			mode_q      <= rmst_pkg::MODE_MIN;
			k_q         <= '0;
			base_q      <= '0;
			start_q     <= '0;
			pos1_q      <= '0;
			acc_q       <= '0;
			len_q       <= '0;
			l_q         <= '0;
			r_q         <= '0;
			res_ans_q   <= '0;
			res_stat_q  <= rmst_pkg::ST_OK;
			out_valid_q <= 1'b0;
			answer_q    <= '0;
			status_q    <= rmst_pkg::ST_OK;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						res_ans_q <= '0;
						unique case (opcode)
							rmst_pkg::OP_CLEAR: begin
								count_q    <= '0;
								res_stat_q <= rmst_pkg::ST_OK;
								state_q    <= S_DONE;
							end
							rmst_pkg::OP_APPEND: begin
								if (full) begin
									res_stat_q <= rmst_pkg::ST_FULL;
									state_q    <= S_DONE;
								end else begin
									res_stat_q <= rmst_pkg::ST_OK;
									count_q    <= count_q + CW'(1);
									acc_q      <= value;
									pos1_q     <= pos1_w;
									k_q        <= KW'(1);
									base_q     <= AW'(MAX_ELEMENTS);
									start_q    <= pos_w - DW'(1);
									state_q    <= (pos1_w >= DW'(2)) ? S_LEVEL : S_DONE;
								end
							end
							rmst_pkg::OP_QUERY: begin
								if (bad_range) begin
									res_stat_q <= rmst_pkg::ST_BAD;
									state_q    <= S_DONE;
								end else begin
									res_stat_q <= rmst_pkg::ST_OK;
									len_q      <= right_index - left_index + 1'b1;
									l_q        <= left_index;
									r_q        <= right_index;
									k_q        <= '0;
									base_q     <= '0;
									state_q    <= S_QLOG;
								end
							end
							default: begin
								res_stat_q <= rmst_pkg::ST_OK;
								state_q    <= S_DONE;
							end
						endcase
					end
				end
				S_LEVEL: begin
					acc_q <= mrg_out;
					if (lvl_more) begin
						k_q     <= k_next;
						base_q  <= base_q + AW'(MAX_ELEMENTS);
						start_q <= start_next;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_QLOG: begin
					if (q_more) begin
						k_q    <= k_next;
						base_q <= base_q + AW'(MAX_ELEMENTS);
					end else begin
						state_q <= S_QRD2;
					end
				end
				S_QRD2: begin
					acc_q   <= mem_rdata;
					state_q <= S_QMRG;
				end
				S_QMRG: begin
					res_ans_q <= mrg_out;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						answer_q <= res_ans_q;
						status_q <= res_stat_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign answer    = answer_q;
	assign status    = status_q;

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result appeared without a finished transaction");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		DW'(count_q) <= DW'(MAX_ELEMENTS))
		else $error("loaded count above table size");

	a_append_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && opcode == rmst_pkg::OP_APPEND && !full)
		|=> count_q == $past(count_q) + 1'b1)
		else $error("append did not advance loaded count");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != rmst_pkg::ST_OK) |-> answer == '0)
		else $error("nonzero answer with error status");

endmodule

// ===== sv/rmst_merge.sv =====
// shared merge unit: signed min, signed max, bitwise and, bitwise or
module rmst_merge (
	input  rmst_pkg::mode_t mode,
	input  rmst_pkg::data_t x,
	input  rmst_pkg::data_t y,
	output rmst_pkg::data_t result
);

	always_comb begin
		unique case (mode)
			rmst_pkg::MODE_MIN: result = (x <= y) ? x : y;
			rmst_pkg::MODE_MAX: result = (x >= y) ? x : y;
			rmst_pkg::MODE_AND: result = x & y;
			rmst_pkg::MODE_OR:  result = x | y;
		endcase
	end

endmodule

// ===== sv/rmst_mem.sv =====
// level table storage: one write port, one registered read port
module rmst_mem #(
	parameter int DEPTH = rmst_pkg::MAX_ELEMENTS_DEF * rmst_pkg::LEVELS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  rmst_pkg::data_t wdata,
	input  logic [AW-1:0]   raddr,
	output rmst_pkg::data_t rdata
);

	rmst_pkg::data_t mem_q [DEPTH];
	rmst_pkg::data_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sim/range_min_sparse_table_checker.sv =====
// checker for the range-query sparse table: watches both channels, predicts each result and compares
module range_min_sparse_table_checker
	import rmst_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int LEVELS       = LEVELS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_wr_en,
	input  mode_t   cfg_wr_data,
	input  logic    in_valid,
	input  logic    in_stall,
	input  opcode_t opcode,
	input  data_t   value,
	input  idx_t    left_index,
	input  idx_t    right_index,
	input  logic    out_valid,
	input  logic    out_stall,
	input  data_t   answer,
	input  status_t status,
	output int      errors,
	output int      outstanding
);

	typedef struct packed {
		data_t   answer;
		status_t status;
	} query_result_t;

	query_result_t expected_results[$];
	data_t         window_merge [LEVELS][MAX_ELEMENTS];
	int unsigned   elem_count;
	mode_t         cur_mode;

	function automatic data_t merge_pair(input mode_t m, input data_t a, input data_t b);
		case (m)
			MODE_MIN: return (a <= b) ? a : b;
			MODE_MAX: return (a >= b) ? a : b;
			MODE_AND: return a & b;
			default:  return a | b;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	task automatic apply_transaction(input opcode_t op, input data_t v, input idx_t l,
			input idx_t r, output query_result_t res);
		int unsigned pos;
		int unsigned span;
		int unsigned lvl;
		int unsigned len;
		res = '0;
		case (op)
			OP_CLEAR: begin
				elem_count = 0;
			end
			OP_APPEND: begin
				if (elem_count >= MAX_ELEMENTS) begin
					res.status = ST_FULL;
				end else begin
					pos = elem_count;
					window_merge[0][pos] = v;
					for (lvl = 1; lvl < LEVELS; lvl++) begin
						span = 1 << lvl;
						if (pos + 1 < span)
							break;
						window_merge[lvl][pos + 1 - span] = merge_pair(cur_mode,
							window_merge[lvl - 1][pos + 1 - span],
							window_merge[lvl - 1][pos + 1 - span + span / 2]);
					end
					elem_count = pos + 1;
				end
			end
			OP_QUERY: begin
				if (l == 0 || l > r || r > elem_count) begin
					res.status = ST_BAD;
				end else begin
					len = r - l + 1;
					lvl = 0;
					while (lvl + 1 < LEVELS && (len >> (lvl + 1)) != 0)
						lvl++;
					span = 1 << lvl;
					res.answer = merge_pair(cur_mode, window_merge[lvl][l - 1],
						window_merge[lvl][r - span]);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		query_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			elem_count = 0;
			cur_mode = MODE_MIN;
			errors = 0;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en)
				cur_mode = cfg_wr_data;
			if (in_valid && !in_stall) begin
				apply_transaction(opcode, value, left_index, right_index, want);
				expected_results.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no transaction pending");
				end else begin
					want = expected_results.pop_front();
					if (answer !== want.answer)
						report_mismatch($sformatf("answer %h, expected %h", answer, want.answer));
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== sim/range_min_sparse_table_core_tb.sv =====
// testbench top for the range-query sparse table: clock, reset, stimulus and verdict
module range_min_sparse_table_core_tb;
	import rmst_pkg::*;

	localparam opcode_t OP_UNUSED = 2'd3;
	localparam data_t   MOST_NEG  = {1'b1, {63{1'b0}}};
	localparam data_t   MOST_POS  = {1'b0, {63{1'b1}}};
	localparam idx_t    IDX_ALL   = {IDX_W{1'b1}};

	logic    clk         = 1'b0;
	logic    arst_n      = 1'b0;
	logic    cfg_wr_en   = 1'b0;
	mode_t   cfg_wr_data = MODE_MIN;
	logic    in_valid    = 1'b0;
	logic    in_stall;
	opcode_t opcode      = OP_CLEAR;
	data_t   value       = '0;
	idx_t    left_index  = '0;
	idx_t    right_index = '0;
	logic    out_valid;
	logic    out_stall   = 1'b0;
	data_t   answer;
	status_t status;

	int          errors;
	int          outstanding;
	int unsigned fill          = 0;
	logic        quiet         = 1'b0;
	logic        pressure_req  = 1'b0;
	logic        pressure_done = 1'b0;
	int          hold_left     = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	range_min_sparse_table_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.value       (value),
		.left_index  (left_index),
		.right_index (right_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.answer      (answer),
		.status      (status)
	);

	range_min_sparse_table_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.value       (value),
		.left_index  (left_index),
		.right_index (right_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.answer      (answer),
		.status      (status),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// receiver: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (pressure_req && !pressure_done) begin
			out_stall     <= 1'b1;
			hold_left     <= 300;
			pressure_done <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 14);
		end
	end

	function automatic data_t rand_value();
		case ($urandom_range(7))
			0:       return MOST_NEG;
			1:       return MOST_POS;
			2, 3:    return data_t'(int'($urandom_range(200)) - 100);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic idx_t rand_idx();
		return idx_t'($urandom_range(2047));
	endfunction

	task automatic send_item(input opcode_t op, input data_t v, input idx_t l, input idx_t r);
		while (!quiet && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		value       <= v;
		left_index  <= l;
		right_index <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (op == OP_CLEAR)
			fill = 0;
		else if (op == OP_APPEND && fill < MAX_ELEMENTS_DEF)
			fill++;
	endtask

	task automatic set_mode(input mode_t m);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic rand_query();
		int unsigned sel;
		int unsigned l;
		int unsigned r;
		sel = $urandom_range(99);
		if (fill != 0 && sel < 85) begin
			l = $urandom_range(fill, 1);
			if ($urandom_range(1))
				r = $urandom_range(fill, l);
			else
				r = (l + $urandom_range(15) > fill) ? fill : l + $urandom_range(15);
		end else if (sel < 90) begin
			l = 0;
			r = $urandom_range(2047);
		end else if (sel < 95) begin
			l = $urandom_range(2047, 2);
			r = $urandom_range(l - 1, 1);
		end else begin
			r = $urandom_range(2047, fill + 1);
			l = $urandom_range(r, 1);
		end
		send_item(OP_QUERY, rand_value(), idx_t'(l), idx_t'(r));
	endtask

	task automatic rand_item();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 3)
			send_item(OP_CLEAR, rand_value(), rand_idx(), rand_idx());
		else if (sel < 5)
			send_item(OP_UNUSED, rand_value(), rand_idx(), rand_idx());
		else if (sel < 45)
			send_item(OP_APPEND, rand_value(), rand_idx(), rand_idx());
		else
			rand_query();
	endtask

	initial begin : stimulus
		mode_t mode_plan [7];
		int    ph;
		int    i;
		mode_plan = '{MODE_MIN, MODE_MAX, MODE_AND, MODE_OR, MODE_MAX, MODE_MIN, MODE_MIN};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_QUERY, '0, 11'd1, 11'd1);
		send_item(OP_APPEND, MOST_NEG, '0, '0);
		send_item(OP_APPEND, MOST_POS, '0, '0);
		send_item(OP_APPEND, '0, '0, '0);
		send_item(OP_APPEND, '1, '0, '0);
		send_item(OP_APPEND, 64'sd5, '0, '0);
		send_item(OP_QUERY, '0, 11'd1, 11'd5);
		send_item(OP_QUERY, '0, 11'd2, 11'd3);
		send_item(OP_QUERY, '0, 11'd3, 11'd3);
		send_item(OP_QUERY, '0, 11'd0, 11'd2);
		send_item(OP_QUERY, '0, 11'd3, 11'd2);
		send_item(OP_QUERY, '0, 11'd1, 11'd6);
		send_item(OP_QUERY, '0, IDX_ALL, IDX_ALL);
		send_item(OP_UNUSED, '1, IDX_ALL, IDX_ALL);
		send_item(OP_QUERY, '1, 11'd1, 11'd4);
		send_item(OP_CLEAR, '1, IDX_ALL, IDX_ALL);
		send_item(OP_QUERY, '0, 11'd1, 11'd1);
		send_item(OP_APPEND, -64'sd7, '0, '0);
		send_item(OP_APPEND, 64'sd3, '0, '0);
		send_item(OP_QUERY, '0, 11'd1, 11'd2);

		for (ph = 0; ph < 7; ph++) begin
			set_mode((ph > 4) ? mode_t'($urandom_range(3)) : mode_plan[ph]);
			if (ph == 4) begin
				send_item(OP_CLEAR, rand_value(), rand_idx(), rand_idx());
				for (i = 0; i < MAX_ELEMENTS_DEF; i++) begin
					send_item(OP_APPEND, rand_value(), rand_idx(), rand_idx());
					if (i % 32 == 31)
						rand_query();
				end
				for (i = 0; i < 5; i++)
					send_item(OP_APPEND, rand_value(), rand_idx(), rand_idx());
				send_item(OP_QUERY, '0, 11'd1, 11'd1024);
				for (i = 0; i < 20; i++)
					rand_query();
				// windows were built under max, queries now merge under or
				set_mode(MODE_OR);
				send_item(OP_QUERY, '0, 11'd1, 11'd1024);
				send_item(OP_QUERY, '0, 11'd1, 11'd1023);
				send_item(OP_QUERY, '0, 11'd2, 11'd1024);
				for (i = 0; i < 30; i++)
					rand_query();
			end else begin
				if (ph == 1)
					quiet <= 1'b1;
				if ($urandom_range(4) != 0)
					send_item(OP_CLEAR, rand_value(), rand_idx(), rand_idx());
				for (i = 0; i < 40; i++) begin
					if (ph == 2 && i == 8)
						pressure_req <= 1'b1;
					rand_item();
				end
				quiet <= 1'b0;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("range_min_sparse_table_core_tb: clean");
		else
			$display("range_min_sparse_table_core_tb: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("range_min_sparse_table_core_tb: errors");
		$finish;
	end

endmodule
